// File: rtl/core/camt_pkg.sv
// Shared types, codes and the pattern compare for the cron alarm match table.
// No dependencies; imported by cron_alarm_match_table.
`timescale 1ns / 1ps
package camt_pkg;

	localparam int PAT_W  = 28;
	localparam int TIME_W = 24;
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 24;

	typedef logic [PAT_W-1:0]  pattern_t;
	typedef logic [TIME_W-1:0] tick_time_t;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_INSERT = 2'd1,
		OP_CANCEL = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_FIRED   = 2'd0,
		KIND_INSERT  = 2'd1,
		KIND_CANCEL  = 2'd2,
		KIND_NO_FIRE = 2'd3
	} kind_t;

	// A pattern field with its sign bit set matches any value.
	function automatic logic pattern_match(input pattern_t pat, input tick_time_t t);
		logic m_min, m_hour, m_day, m_mon, m_wday;
		m_min  = pat[6]  || (pat[6:0]   == {1'b0, t[5:0]});
		m_hour = pat[12] || (pat[12:7]  == {1'b0, t[10:6]});
		m_day  = pat[18] || (pat[18:13] == {1'b0, t[15:11]});
		m_mon  = pat[23] || (pat[23:19] == {1'b0, t[19:16]});
		m_wday = pat[27] || (pat[27:24] == {1'b0, t[22:20]});
		return m_min && m_hour && m_day && m_mon && m_wday;
	endfunction

endpackage

// File: rtl/core/cron_alarm_match_table.sv
// Cron alarm match table: entry memory, slot walk and result stream.
// Depends on camt_pkg.
`timescale 1ns / 1ps
//
// Channel  Dir  Transfer when        Payload
// s_*      in   s_tvalid & s_tready  tuser opcode, tdata cancel id, patterns, tick time
// m_*      out  m_tvalid & m_tready  tuser kind, tdata id and ok flag, tlast final result
//
// One item at a time: every operation but OP_NONE walks the slots through the entry
// memory, one slot a cycle, reading the next slot while writing back the one read before
// it. A tick, a failed insert or a failed cancel keeps s_tready low until every slot is
// walked; a successful insert or cancel stops at the slot it needs. A full output register
// stalls the walk. Reset clears the valid bits, id counter and tick time at once; the entry
// memory needs no clearing.
module cron_alarm_match_table #(
	parameter int ENTRIES = 16,
	parameter int ID_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cancel_id, pat_minute, pat_hour, pat_day, pat_month, pat_weekday,
	// now_minute, now_hour, now_day, now_month, now_weekday
	input  logic [camt_pkg::S_DATA_W-1:0] s_tdata,
	// opcode
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// entry_id, ok_flag
	output logic [camt_pkg::M_DATA_W-1:0] m_tdata,
	// kind
	output logic [1:0]                    m_tuser,
	output logic                          m_tlast
);
	import camt_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int XW = (ID_BITS > 16) ? ID_BITS : 16;
	localparam int MW = ID_BITS + PAT_W + TIME_W;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t               state_q;
	opcode_t              op_q;
	logic [15:0]          cancel_id_q;
	pattern_t             pattern_q;
	tick_time_t           now_q;
	tick_time_t           latest_q;
	logic [ID_BITS-1:0]   next_id_q;
	logic [ENTRIES-1:0]   valid_q;
	logic [CW-1:0]        iss_q;
	logic                 eval_vld_s1;
	logic [IW-1:0]        eval_idx_s1;
	logic [MW-1:0]        rd_data_s1;
	logic                 hold_vld_q;
	logic [ID_BITS-1:0]   hold_id_q;

	logic                 m_tvalid_q;
	kind_t                out_kind_q;
	logic [15:0]          out_id_q;
	logic                 out_ok_q;
	logic                 out_last_q;

	logic [MW-1:0]        mem [ENTRIES];

	logic [ID_BITS-1:0]   ent_ident;
	pattern_t             ent_pattern;
	tick_time_t           ent_fired;
	logic                 ent_valid;
	logic                 hit;
	logic                 done;
	logic                 need_push;
	logic                 out_free;
	logic                 adv;
	logic                 push;
	logic                 rd_en;
	logic                 mem_we;
	logic [MW-1:0]        mem_wdata;
	kind_t                push_kind;
	logic [15:0]          push_id;
	logic                 push_ok;
	logic                 push_last;
	logic [15:0]          next_id16;
	logic [15:0]          hold_id16;
	logic                 s_xfer;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = out_kind_q;
	assign m_tdata   = {{(M_DATA_W - 17){1'b0}}, out_ok_q, out_id_q};
	assign m_tlast   = out_last_q;

	assign ent_ident   = rd_data_s1[MW-1 -: ID_BITS];
	assign ent_pattern = rd_data_s1[TIME_W +: PAT_W];
	assign ent_fired   = rd_data_s1[TIME_W-1:0];
	assign ent_valid   = valid_q[eval_idx_s1];
	assign next_id16   = 16'(next_id_q);
	assign hold_id16   = 16'(hold_id_q);
	assign out_free    = !m_tvalid_q || m_tready;

	always_comb begin
		hit       = 1'b0;
		done      = (state_q == ST_WALK) && (iss_q == CW'(ENTRIES)) && !eval_vld_s1;
		need_push = 1'b0;
		push_kind = KIND_NO_FIRE;
		push_id   = '0;
		push_ok   = 1'b0;
		push_last = 1'b1;
		mem_wdata = {ent_ident, ent_pattern, now_q};
		if (state_q == ST_WALK && eval_vld_s1) begin
			case (op_q)
				OP_TICK: begin
					hit = ent_valid && pattern_match(ent_pattern, now_q) && (ent_fired != now_q);
				end
				OP_INSERT: begin
					hit = !ent_valid;
				end
				OP_CANCEL: begin
					hit = ent_valid && (XW'(ent_ident) == XW'(cancel_id_q));
				end
				default: begin
					hit = 1'b0;
				end
			endcase
		end
		case (op_q)
			OP_TICK: begin
				need_push = (hit && hold_vld_q) || done;
				push_kind = (hit || hold_vld_q) ? KIND_FIRED : KIND_NO_FIRE;
				push_id   = (hit || hold_vld_q) ? hold_id16 : 16'd0;
				push_last = done;
			end
			OP_INSERT: begin
				need_push = hit || done;
				push_kind = KIND_INSERT;
				push_id   = next_id16;
				push_ok   = hit;
				mem_wdata = {next_id_q, pattern_q, latest_q};
			end
			OP_CANCEL: begin
				need_push = hit || done;
				push_kind = KIND_CANCEL;
				push_id   = cancel_id_q;
				push_ok   = hit;
			end
			default: begin
				need_push = done;
			end
		endcase
	end

	assign adv    = (state_q == ST_WALK) && !(need_push && !out_free);
	assign push   = (state_q == ST_WALK) && need_push && out_free;
	assign rd_en  = adv && (iss_q != CW'(ENTRIES));
	assign mem_we = adv && hit && (op_q == OP_TICK || op_q == OP_INSERT);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[eval_idx_s1] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[iss_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_NONE;
			latest_q    <= '0;
			next_id_q   <= '0;
			valid_q     <= '0;
			iss_q       <= '0;
			eval_vld_s1 <= 1'b0;
			hold_vld_q  <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						op_q        <= opcode_t'(s_tuser);
						cancel_id_q <= s_tdata[15:0];
						pattern_q   <= s_tdata[43:16];
						now_q       <= {1'b1, s_tdata[66:44]};
						iss_q       <= '0;
						eval_vld_s1 <= 1'b0;
						hold_vld_q  <= 1'b0;
						if (opcode_t'(s_tuser) == OP_TICK) begin
							latest_q <= {1'b1, s_tdata[66:44]};
						end
						if (opcode_t'(s_tuser) != OP_NONE) begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (adv) begin
						if (iss_q != CW'(ENTRIES)) begin
							iss_q       <= iss_q + CW'(1);
							eval_idx_s1 <= iss_q[IW-1:0];
						end
						eval_vld_s1 <= (iss_q != CW'(ENTRIES))
							&& !(hit && (op_q == OP_INSERT || op_q == OP_CANCEL));
						if (hit) begin
							case (op_q)
								OP_TICK: begin
									hold_vld_q <= 1'b1;
									hold_id_q  <= ent_ident;
								end
								OP_INSERT: begin
									valid_q[eval_idx_s1] <= 1'b1;
									next_id_q            <= next_id_q + ID_BITS'(1);
									state_q              <= ST_IDLE;
								end
								OP_CANCEL: begin
									valid_q[eval_idx_s1] <= 1'b0;
									state_q              <= ST_IDLE;
								end
								default: begin
									state_q <= ST_IDLE;
								end
							endcase
						end
						if (done) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (push) begin
				m_tvalid_q <= 1'b1;
				out_kind_q <= push_kind;
				out_id_q   <= push_id;
				out_ok_q   <= push_ok;
				out_last_q <= push_last;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule
